### sv/gbr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the 3x3 blur arithmetic for the gaussian blur block
package gbr_pkg;

    // channel and pixel widths
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int CNT_W      = 4;

    // rounding of the kernel sum (weights sum to 16)
    localparam int ACC_W      = 13;
    localparam int BLUR_ROUND = 8;
    localparam int BLUR_SHIFT = 4;
    localparam int CH_MAX     = 255;

    typedef logic [PIX_W-1:0] pix_t;

    // 3x3 window, row-major, element 0 is top-left
    typedef logic [8:0][PIX_W-1:0] win_t;

    // one column of the two line stores
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } pair_t;

    // control of the item in the filter stage
    typedef struct packed {
        logic valid;
        logic flush;
        logic x0;
        logic y0;
        logic last;
        pix_t pix;
    } stage_ctrl_t;

    typedef struct packed {
        pix_t pix;
        logic run_last;
        logic frame_last;
    } result_t;

    // up to two results per item, packed from res0
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

    typedef struct packed {
        logic en;
        pix_t older;
        pix_t newer;
    } store_wr_t;

    // kernel 1 2 1 / 2 4 2 / 1 2 1 on each channel, rounded and saturated
    function automatic pix_t blur3x3(input win_t w);
        pix_t                  res;
        logic [ACC_W-1:0]      acc;
        logic [ACC_W-1:0]      edge_sum;
        logic [ACC_W-1:0]      side_sum;
        logic [ACC_W-BLUR_SHIFT-1:0] v;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            edge_sum = ACC_W'(w[0][ch*CH_W +: CH_W]) + ACC_W'(w[2][ch*CH_W +: CH_W])
                     + ACC_W'(w[6][ch*CH_W +: CH_W]) + ACC_W'(w[8][ch*CH_W +: CH_W]);
            side_sum = ACC_W'(w[1][ch*CH_W +: CH_W]) + ACC_W'(w[3][ch*CH_W +: CH_W])
                     + ACC_W'(w[5][ch*CH_W +: CH_W]) + ACC_W'(w[7][ch*CH_W +: CH_W]);
            acc = edge_sum + (side_sum << 1) + (ACC_W'(w[4][ch*CH_W +: CH_W]) << 2)
                + ACC_W'(BLUR_ROUND);
            v = acc[ACC_W-1:BLUR_SHIFT];
            res[ch*CH_W +: CH_W] = (v > (ACC_W-BLUR_SHIFT)'(CH_MAX)) ? CH_W'(CH_MAX)
                                                                      : v[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/gbr_in_if.sv
`timescale 1ns / 1ps
// input channel: pixel and flush beats
interface gbr_in_if;
    import gbr_pkg::*;

    logic            valid;
    logic            ready;
    logic            opcode;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

### sv/gbr_out_if.sv
`timescale 1ns / 1ps
// output channel: filtered pixel beats
interface gbr_out_if;
    import gbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            run_last;
    logic            frame_last;

    modport source (output valid, out_red, out_green, out_blue, run_last, frame_last,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, run_last, frame_last,
                    output ready);
endinterface

### sv/gbr_line_store.sv
`timescale 1ns / 1ps
// one line store: synchronous ram with registered read and write-to-read forwarding
module gbr_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 24,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              fwd_next;

    // ram array, read sees the old word on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // a write landing on the address being read is forwarded
    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;
endmodule

### sv/gbr_filter.sv
`timescale 1ns / 1ps
// filter stage: window update, bottom-row column pair, blur and store write-back
module gbr_filter (
    input  logic                clk,
    input  gbr_pkg::stage_ctrl_t ctrl,
    input  gbr_pkg::pix_t       older_rd,
    input  gbr_pkg::pix_t       newer_rd,
    output gbr_pkg::push_t      push,
    output gbr_pkg::store_wr_t  store_wr
);
    import gbr_pkg::*;

    win_t                 win_reg;
    pair_t                fl_l_reg;
    pair_t                fl_c_reg;
    win_t                 w1;
    win_t                 w2;
    win_t                 fw;
    logic [2:0][PIX_W-1:0] ncol;
    pix_t                 top;
    pix_t                 mid;
    result_t              res_a;
    result_t              res_b;
    logic                 a_ok;
    logic                 b_ok;

    // rows above the incoming pixel; row 0 replicates itself upward
    assign top = ctrl.y0 ? ctrl.pix : older_rd;
    assign mid = ctrl.y0 ? ctrl.pix : newer_rd;

    // shifted window, and the extra shift that replicates the right edge
    always_comb
    begin
        ncol[0] = top;
        ncol[1] = mid;
        ncol[2] = ctrl.pix;
        for (int r = 0; r < 3; r++)
        begin
            w1[r*3+0] = ctrl.x0 ? ncol[r] : win_reg[r*3+1];
            w1[r*3+1] = ctrl.x0 ? ncol[r] : win_reg[r*3+2];
            w1[r*3+2] = ncol[r];
            w2[r*3+0] = w1[r*3+1];
            w2[r*3+1] = w1[r*3+2];
            w2[r*3+2] = w1[r*3+2];
        end
    end

    // bottom-row window, last row replicated downward
    always_comb
    begin
        fw[0] = fl_l_reg.older;
        fw[1] = fl_c_reg.older;
        fw[2] = older_rd;
        fw[3] = fl_l_reg.newer;
        fw[4] = fl_c_reg.newer;
        fw[5] = newer_rd;
        fw[6] = fl_l_reg.newer;
        fw[7] = fl_c_reg.newer;
        fw[8] = newer_rd;
    end

    // results of this item, packed from the first slot
    always_comb
    begin
        a_ok             = ctrl.valid && (ctrl.flush || (!ctrl.x0 && !ctrl.y0));
        b_ok             = ctrl.valid && !ctrl.flush && ctrl.last && !ctrl.y0;
        res_a.pix        = blur3x3(ctrl.flush ? fw : w1);
        res_a.run_last   = ctrl.flush || !ctrl.last;
        res_a.frame_last = ctrl.flush && ctrl.last;
        res_b.pix        = blur3x3(w2);
        res_b.run_last   = 1'b1;
        res_b.frame_last = 1'b0;
        push.res0        = a_ok ? res_a : res_b;
        push.res1        = res_b;
        push.cnt         = {1'b0, a_ok} + {1'b0, b_ok};
    end

    // line store write-back: rows move up by one
    always_comb
    begin
        store_wr.en    = ctrl.valid && !ctrl.flush;
        store_wr.older = mid;
        store_wr.newer = ctrl.pix;
    end

    // window and bottom-row column pair
    always_ff @(posedge clk)
    begin
        if (ctrl.valid && !ctrl.flush)
        begin
            win_reg <= w1;
            if (ctrl.x0)
            begin
                fl_l_reg <= '{older: mid, newer: ctrl.pix};
                fl_c_reg <= '{older: mid, newer: ctrl.pix};
            end
        end
        else if (ctrl.valid && ctrl.flush)
        begin
            fl_l_reg <= fl_c_reg;
            fl_c_reg <= '{older: older_rd, newer: newer_rd};
        end
    end
endmodule

### sv/gbr_out_fifo.sv
`timescale 1ns / 1ps
// result queue: takes up to two results a cycle, drives the output channel
module gbr_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbr_pkg::push_t        push,
    output logic [gbr_pkg::CNT_W-1:0] count,
    gbr_out_if.source             result_ch
);
    import gbr_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_inc;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  pop;
    result_t               head;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.res1;
        end
    end

    // pointers and fill count
    assign pop         = result_ch.valid && result_ch.ready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head of queue to the output channel
    assign head                 = mem[rd_ptr_reg];
    assign count                = count_reg;
    assign result_ch.valid      = (count_reg != '0);
    assign result_ch.out_red    = head.pix[2*CH_W +: CH_W];
    assign result_ch.out_green  = head.pix[CH_W +: CH_W];
    assign result_ch.out_blue   = head.pix[0 +: CH_W];
    assign result_ch.run_last   = head.run_last;
    assign result_ch.frame_last = head.frame_last;
endmodule

### sv/gaussian_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// top level of the streaming 3x3 gaussian blur with replicated borders
//
//  channel     role    handshake            payload
//  pixel_ch    sink    valid/ready          opcode, in_red, in_green, in_blue
//  result_ch   source  valid/ready          out_red, out_green, out_blue, run_last, frame_last
//  cfg port    sink    cfg_wr_en (no wait)  cfg_index, cfg_data
//
// one item is taken every cycle while ready is high; its results pass s1_reg, then the queue
// a pixel reads both line stores in the accept cycle and writes them back in the next cycle;
// past row 0, a last pixel at x>0 gives two results; an 8-beat queue absorbs the extra beat
// pixel_ch.ready drops when the queue cannot take two more results behind the filter stage
// reset clears config, counters, s1_reg and queue; line stores and window need no clearing
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gbr_in_if.sink                         pixel_ch,
    gbr_out_if.source                      result_ch,
    input  logic                           cfg_wr_en,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbr_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    logic                flushing_reg;
    logic                flushing_next;
    stage_ctrl_t         s1_reg;
    stage_ctrl_t         s1_next;
    logic [COL_W-1:0]    s1_addr_reg;

    logic [COL_W-1:0]    last_col;
    logic [HEIGHT_W-1:0] last_row;
    logic                at_last_col;
    logic                at_last_row;
    logic [COL_W-1:0]    col_inc;
    logic                in_fire;
    logic                is_flush;
    logic                take;
    logic [COL_W-1:0]    rd_addr;
    pix_t                in_pix;
    pix_t                older_rd;
    pix_t                newer_rd;
    push_t               push;
    store_wr_t           store_wr;
    logic [CNT_W-1:0]    fifo_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
            endcase
        end
    end

    // effective frame limits
    always_comb
    begin
        priority if (width_reg == '0)
            last_col = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(width_reg - 1'b1);
    end

    assign last_row    = (height_reg == '0) ? '0 : height_reg - 1'b1;
    assign at_last_col = (col_reg == last_col);
    assign at_last_row = (row_reg >= last_row);
    assign col_inc     = col_reg + 1'b1;

    // input handshake
    assign in_fire  = pixel_ch.valid && pixel_ch.ready;
    assign is_flush = (pixel_ch.opcode == OP_FLUSH);
    assign take     = in_fire && (is_flush ? flushing_reg : !flushing_reg);
    assign in_pix   = {pixel_ch.in_red, pixel_ch.in_green, pixel_ch.in_blue};
    assign pixel_ch.ready = ({1'b0, fifo_count} + (CNT_W + 1)'(push.cnt))
                            <= (CNT_W + 1)'(FIFO_DEPTH - 2);

    // raster position and flush phase
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        if (cfg_wr_en)
        begin
            col_next      = '0;
            row_next      = '0;
            flushing_next = 1'b0;
        end
        else if (take && is_flush)
        begin
            if (at_last_col)
            begin
                col_next      = '0;
                row_next      = '0;
                flushing_next = 1'b0;
            end
            else
            begin
                col_next = col_inc;
            end
        end
        else if (take)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    flushing_next = 1'b1;
                    row_next      = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    // store read address: own column for a pixel, right neighbor for a flush (own at row end)
    assign rd_addr = (is_flush && !at_last_col) ? col_inc : col_reg;

    // filter stage control
    always_comb
    begin
        s1_next.valid = take;
        s1_next.flush = is_flush;
        s1_next.x0    = (col_reg == '0);
        s1_next.y0    = (row_reg == '0);
        s1_next.last  = at_last_col;
        s1_next.pix   = in_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
            s1_reg       <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            flushing_reg <= flushing_next;
            s1_reg       <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= rd_addr;
    end

    // line stores: rows y-2 and y-1
    gbr_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_older_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (older_rd),
        .wr_en   (store_wr.en),
        .wr_addr (s1_addr_reg),
        .wr_data (store_wr.older)
    );

    gbr_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_newer_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (newer_rd),
        .wr_en   (store_wr.en),
        .wr_addr (s1_addr_reg),
        .wr_data (store_wr.newer)
    );

    // window and blur
    gbr_filter u_filter (
        .clk      (clk),
        .ctrl     (s1_reg),
        .older_rd (older_rd),
        .newer_rd (newer_rd),
        .push     (push),
        .store_wr (store_wr)
    );

    // result queue
    gbr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .count     (fifo_count),
        .result_ch (result_ch)
    );
endmodule

### sv/gbr_checker.sv
`timescale 1ns / 1ps
// port-level checks of the gaussian blur top level, with its bind
module gbr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [gbr_pkg::CH_W-1:0] out_red,
    input logic [gbr_pkg::CH_W-1:0] out_green,
    input logic [gbr_pkg::CH_W-1:0] out_blue,
    input logic run_last,
    input logic frame_last
);
    import gbr_pkg::*;

    // the frame's final beat also closes its item's run
    a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> run_last)
        else $error("frame_last without run_last");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(out_red) && $stable(out_green) && $stable(out_blue)
            && $stable(run_last) && $stable(frame_last))
        else $error("stalled result beat changed");

    // an empty result queue refills only from an accepted input beat
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without a matching input beat");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");
endmodule

bind gaussian_blur_3x3_rgb gbr_checker u_gbr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel_ch.valid),
    .in_ready   (pixel_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_red    (result_ch.out_red),
    .out_green  (result_ch.out_green),
    .out_blue   (result_ch.out_blue),
    .run_last   (result_ch.run_last),
    .frame_last (result_ch.frame_last)
);

### tb/gaussian_blur_3x3_rgb_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming 3x3 rgb gaussian blur against a behavioral model
module gaussian_blur_3x3_rgb_test;
    import gbr_pkg::*;

    localparam int MAX_W     = 1024;
    localparam int HALF_CLK  = 5;
    // worst case is about 2000 beats, two results each, both sides stalling most cycles
    localparam int CYCLE_CAP = 400000;
    localparam int TAIL      = 20;

    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct {
        logic op;
        pix_t pix;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbr_in_if  pixel_ch ();
    gbr_out_if result_ch ();

    gaussian_blur_3x3_rgb #(
        .MAX_WIDTH (MAX_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_ch  (pixel_ch),
        .result_ch (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_CLK) clk = ~clk;

    // pending beats, expected filtered pixels, run bookkeeping
    beat_t   pending_q[$];
    result_t expected_q[$];
    int      fail_count   = 0;
    int      cycle_count  = 0;
    int      beats_queued = 0;
    int      send_idle_pct;
    int      recv_idle_pct;

    // blur model state
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pix_t        older_row [MAX_W];
    pix_t        newer_row [MAX_W];
    window_t     win_px;
    int unsigned col_idx;
    int unsigned row_idx;
    bit          flushing;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // weights 1 2 1 / 2 4 2 / 1 2 1, sum rounded by 8 and divided by 16
    function automatic pix_t blur_of(window_t w);
        pix_t        r;
        int unsigned acc;
        int unsigned wt;
        r = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 8;
            for (int k = 0; k < 9; k++)
            begin
                wt = ((k / 3 == 1) ? 2 : 1) * ((k % 3 == 1) ? 2 : 1);
                acc += wt * w[k][ch*CH_W +: CH_W];
            end
            acc = acc >> 4;
            if (acc > 255) acc = 255;
            r[ch*CH_W +: CH_W] = CH_W'(acc);
        end
        return r;
    endfunction

    task automatic shift_column(pix_t t, pix_t m, pix_t b);
        pix_t c [3];
        c[0] = t;
        c[1] = m;
        c[2] = b;
        for (int r = 0; r < 3; r++)
        begin
            win_px[r*3]     = win_px[r*3 + 1];
            win_px[r*3 + 1] = win_px[r*3 + 2];
            win_px[r*3 + 2] = c[r];
        end
    endtask

    task automatic expect_pixel(pix_t p, logic rl, logic fl);
        expected_q.push_back(result_t'{pix: p, run_last: rl, frame_last: fl});
    endtask

    task automatic restart_frame();
        col_idx  = 0;
        row_idx  = 0;
        flushing = 0;
    endtask

    task automatic apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_W-1:0];
        else height_reg = data[HEIGHT_W-1:0];
        restart_frame();
    endtask

    // advance the model by one accepted beat, queueing what it should produce
    task automatic predict_beat(logic op, pix_t pix);
        int unsigned w, h, x, y, xl, xr;
        pix_t        top, mid;
        window_t     fw;
        bit          last;
        w = eff_width();
        h = eff_height();
        x = col_idx;
        y = row_idx;
        if (x >= w) x = w - 1;
        last = (x == w - 1);
        if (op == OP_FLUSH)
        begin
            if (!flushing) return;
            // bottom row: the newest row stands in for the row below
            xl = (x != 0) ? x - 1 : 0;
            xr = (x + 1 < w) ? x + 1 : w - 1;
            fw[0] = older_row[xl];
            fw[1] = older_row[x];
            fw[2] = older_row[xr];
            fw[3] = newer_row[xl];
            fw[4] = newer_row[x];
            fw[5] = newer_row[xr];
            fw[6] = fw[3];
            fw[7] = fw[4];
            fw[8] = fw[5];
            expect_pixel(blur_of(fw), 1'b1, last);
            if (last) restart_frame();
            else col_idx = x + 1;
            return;
        end
        if (flushing) return;
        // top row replicates itself upward
        if (y == 0)
        begin
            top = pix;
            mid = pix;
            older_row[x] = pix;
            newer_row[x] = pix;
        end
        else
        begin
            top = older_row[x];
            mid = newer_row[x];
            older_row[x] = mid;
            newer_row[x] = pix;
        end
        // left edge fills the whole window with the first column
        if (x == 0)
        begin
            shift_column(top, mid, pix);
            shift_column(top, mid, pix);
            shift_column(top, mid, pix);
        end
        else
        begin
            shift_column(top, mid, pix);
            if (y > 0) expect_pixel(blur_of(win_px), !last, 1'b0);
        end
        if (last)
        begin
            // right edge repeats the last column
            if (y > 0)
            begin
                shift_column(win_px[2], win_px[5], win_px[8]);
                expect_pixel(blur_of(win_px), 1'b1, 1'b0);
            end
            col_idx = 0;
            if (y + 1 >= h)
            begin
                flushing = 1;
                row_idx  = 0;
            end
            else
            begin
                row_idx = (y + 1) & 16'hFFFF;
            end
        end
        else
        begin
            col_idx = x + 1;
        end
    endtask

    // sender: present queued beats, idling at random, predict on each accepted beat
    always @(posedge clk)
    begin : send_beats
        beat_t nxt;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                predict_beat(pixel_ch.opcode,
                             {pixel_ch.in_red, pixel_ch.in_green, pixel_ch.in_blue});
            if (!(pixel_ch.valid && !pixel_ch.ready))
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    pixel_ch.valid    <= 1'b1;
                    pixel_ch.opcode   <= nxt.op;
                    pixel_ch.in_red   <= nxt.pix[23:16];
                    pixel_ch.in_green <= nxt.pix[15:8];
                    pixel_ch.in_blue  <= nxt.pix[7:0];
                end
                else
                begin
                    pixel_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : collect_results
        result_t want;
        bit      bad;
        if (rst_n)
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("cycle %0d: unexpected result r=%h g=%h b=%h rl=%b fl=%b",
                                 cycle_count, result_ch.out_red, result_ch.out_green,
                                 result_ch.out_blue, result_ch.run_last, result_ch.frame_last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = (result_ch.out_red    !== want.pix[23:16])
                        || (result_ch.out_green  !== want.pix[15:8])
                        || (result_ch.out_blue   !== want.pix[7:0])
                        || (result_ch.run_last   !== want.run_last)
                        || (result_ch.frame_last !== want.frame_last);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("cycle %0d: want r=%h g=%h b=%h rl=%b fl=%b, ",
                                   cycle_count, want.pix[23:16], want.pix[15:8],
                                   want.pix[7:0], want.run_last, want.frame_last);
                            $display("got r=%h g=%h b=%h rl=%b fl=%b",
                                     result_ch.out_red, result_ch.out_green,
                                     result_ch.out_blue, result_ch.run_last,
                                     result_ch.frame_last);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic pix_t rand_pixel();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic push_pixel(pix_t p);
        pending_q.push_back('{op: OP_PIXEL, pix: p});
    endtask

    task automatic push_flush();
        pending_q.push_back('{op: OP_FLUSH, pix: PIX_W'($urandom)});
    endtask

    // sender holds off until every queued beat is taken and every result is back
    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || pixel_ch.valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    // idle block: drained, plus time for beats that leave no result
    task automatic settle();
        wait_drained();
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_config(idx, data);
        @(negedge clk);
    endtask

    // mostly narrow rows; upper data bits are sometimes junk the register drops
    function automatic logic [CFG_DATA_W-1:0] rand_width();
        int unsigned k, v;
        k = $urandom_range(99);
        if (k < 6) v = 0;
        else if (k < 75) v = $urandom_range(1, 6);
        else v = $urandom_range(7, 24);
        if ($urandom_range(3) == 0) return {5'($urandom), WIDTH_W'(v)};
        return CFG_DATA_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_height();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 8) return '0;
        if (k < 12) return '1;
        return CFG_DATA_W'($urandom_range(1, 5));
    endfunction

    task automatic reconfigure();
        settle();
        case ($urandom_range(3))
            0: write_reg(REG_IMAGE_WIDTH, rand_width());
            1: write_reg(REG_IMAGE_HEIGHT, rand_height());
            default:
            begin
                write_reg(REG_IMAGE_WIDTH, rand_width());
                write_reg(REG_IMAGE_HEIGHT, rand_height());
            end
        endcase
    endtask

    // one frame of pixels plus its flush run, with stray beats, optionally cut short
    task automatic send_frame(bit broken);
        int unsigned ew, eh, npix, total, cut, n;
        ew    = eff_width();
        eh    = eff_height();
        npix  = ew * eh;
        total = npix + ew;
        cut   = total;
        if (eh > 8) cut = $urandom_range(1, ew * 4);
        else if (broken) cut = $urandom_range(1, total - 1);
        n = 0;
        for (int unsigned i = 0; i < npix && n < cut; i++)
        begin
            if ($urandom_range(99) < 3) push_flush();
            push_pixel(rand_pixel());
            n++;
        end
        if (n < cut && $urandom_range(99) < 4) wait_drained();
        for (int unsigned x = 0; x < ew && n < cut; x++)
        begin
            if ($urandom_range(99) < 3) push_pixel(rand_pixel());
            push_flush();
            n++;
        end
        beats_queued += n;
    endtask

    task automatic run_phase(int sp, int rp, int budget);
        int start;
        int nf;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        start = beats_queued;
        while (beats_queued - start < budget)
        begin
            reconfigure();
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++)
                send_frame(f == nf - 1 && $urandom_range(99) < 20);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        pixel_ch.valid    = 1'b0;
        pixel_ch.opcode   = OP_PIXEL;
        pixel_ch.in_red   = '0;
        pixel_ch.in_green = '0;
        pixel_ch.in_blue  = '0;
        result_ch.ready   = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_IMAGE_WIDTH;
        cfg_data          = '0;
        send_idle_pct     = 32;
        recv_idle_pct     = 77;

        // model at reset
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        win_px = '0;
        restart_frame();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stray flush, then a partial top row at the reset width
        push_flush();
        push_pixel('0);
        push_pixel('1);
        push_pixel(24'hA5A5A5);
        settle();

        // 3x2 frame with extremes, pause before the flush run
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        push_pixel('1);
        push_pixel('0);
        push_pixel(24'h5A5A5A);
        push_pixel('0);
        push_pixel('1);
        push_pixel(24'h123456);
        wait_drained();
        // pixel during the flush run is dropped, as is a flush after the frame
        push_pixel('1);
        push_flush();
        push_flush();
        push_flush();
        push_flush();
        settle();

        // zero width and height act as one: two single-pixel frames
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        push_pixel('1);
        push_flush();
        push_pixel('0);
        push_flush();
        settle();

        // one-pixel column, junk in the upper width data bits
        write_reg(REG_IMAGE_WIDTH, 16'hF801);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        push_pixel(24'h00FF00);
        push_pixel(24'hFF00FF);
        push_pixel(24'h0F0F0F);
        push_flush();

        // random frames under three stall profiles
        run_phase(32, 77, 230);
        run_phase(77, 32, 230);
        run_phase(0, 0, 230);

        // widest row: oversized width clamps to the line store depth
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        for (int i = 0; i < MAX_W - 1; i++)
            push_pixel(rand_pixel());
        // one column short of the row end: this flush is dropped
        push_flush();
        push_pixel(rand_pixel());
        // the row is complete, so this pixel is dropped
        push_pixel(rand_pixel());
        for (int i = 0; i < 8; i++)
            push_flush();

        wait_drained();
        repeat (TAIL) @(negedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
